// ----- hw/rtl/double_ended_queue_with_reverse_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_REVERSE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_REVERSE_MACROS_SVH

// clocked assertion, disabled while the reset is high
`define DQR_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// shorthand on the checker's own clk and rst
`define DQR_ASSERT(label, prop, msg) \
  `DQR_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

// ----- hw/rtl/dqr_pkg.sv -----
// ----------------------------------------------------------------------------
// dqr_pkg
// Action and status codes, controller states and the command word shared
// by the double-ended queue controller and datapath.
// ----------------------------------------------------------------------------
package dqr_pkg;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_REVERSE    = 3'd4;

  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // carry out the captured action
  } dqr_cmd_t;

endpackage

// ----- hw/rtl/dqr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dqr_ctrl
// Sequencer: takes one word, runs it through the datapath, then holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module dqr_ctrl
  import dqr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dqr_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state == ST_EXEC);

endmodule

// ----- hw/rtl/dqr_datapath.sv -----
// ----------------------------------------------------------------------------
// dqr_datapath
// Circular entry store with first pointer, fill count and direction flag.
// Reversal swaps which physical end serves as the front.
// ----------------------------------------------------------------------------
module dqr_datapath
  import dqr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dqr_cmd_t                       cmd,
  input  logic        [2:0]              action,
  input  logic signed [31:0]             value,
  output logic signed [31:0]             popped_value,
  output logic        [1:0]              status,
  output logic        [$clog2(DEPTH+1)-1:0] entry_count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic        [31:0]   mem [DEPTH];
  logic        [31:0]   rd_data;
  logic        [2:0]    action_q;
  logic        [31:0]   value_q;
  logic        [PW-1:0] first;
  logic        [PW-1:0] first_next;
  logic        [CW-1:0] count;
  logic        [CW-1:0] count_next;
  logic                 reversed;
  logic                 reversed_next;
  logic        [1:0]    status_next;
  logic                 pop_ok_q;

  logic          is_push;
  logic          is_pop;
  logic          at_first;
  logic          full;
  logic          empty;
  logic          push_ok;
  logic          pop_ok;
  logic [PW-1:0] first_dec;
  logic [PW-1:0] first_inc;
  logic [SW-1:0] back_sum;
  logic [PW-1:0] back_pos;
  logic [PW-1:0] last_pos;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic          rd_en;
  logic [PW-1:0] rd_addr;

  always_comb begin
    is_push  = (action_q == ACT_PUSH_FRONT) || (action_q == ACT_PUSH_BACK);
    is_pop   = (action_q == ACT_POP_FRONT) || (action_q == ACT_POP_BACK);
    // front actions use the physical first end unless reversed
    at_first = ((action_q == ACT_PUSH_FRONT) || (action_q == ACT_POP_FRONT)) ^ reversed;
    full     = (count == DEPTH_C);
    empty    = (count == '0);
    push_ok  = is_push && !full;
    pop_ok   = is_pop && !empty;

    first_dec = (first == '0) ? LAST_IDX : first - PW'(1);
    first_inc = (first == LAST_IDX) ? '0 : first + PW'(1);
    back_sum  = SW'(first) + SW'(count);
    back_pos  = (back_sum >= DEPTH_S) ? PW'(back_sum - DEPTH_S) : PW'(back_sum);
    last_pos  = (back_pos == '0) ? LAST_IDX : back_pos - PW'(1);

    wr_en   = cmd.exec && push_ok;
    wr_addr = empty ? first : (at_first ? first_dec : back_pos);
    rd_en   = cmd.exec && pop_ok;
    rd_addr = at_first ? first : last_pos;

    first_next = first;
    if (push_ok && !empty && at_first) begin
      first_next = first_dec;
    end else if (pop_ok && at_first) begin
      first_next = first_inc;
    end

    count_next = count;
    if (push_ok) begin
      count_next = count + CW'(1);
    end else if (pop_ok) begin
      count_next = count - CW'(1);
    end

    reversed_next = reversed ^ (action_q == ACT_REVERSE);

    status_next = STS_DONE;
    if (is_push && full) begin
      status_next = STS_FULL;
    end else if (is_pop && empty) begin
      status_next = STS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first    <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else if (cmd.exec) begin
      first    <= first_next;
      count    <= count_next;
      reversed <= reversed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      value_q  <= value;
    end
    if (cmd.exec) begin
      status   <= status_next;
      pop_ok_q <= pop_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= value_q;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign popped_value = pop_ok_q ? $signed(rd_data) : 32'sd0;
  assign entry_count  = count;

endmodule

// ----- hw/rtl/double_ended_queue_with_reverse.sv -----
// Bounded double-ended queue of signed 32-bit values with order reversal.
// Input channel (in_valid/in_ready) carries one word per action: action
// selects push front, push back, pop front, pop back or reverse, and value
// is the word to push. Output channel (out_valid/out_ready) returns one
// result per action: popped_value, status (done, full, empty) and the
// entry_count held after the action.
// The result is registered: an accepted word is executed in the EXEC state and
// its result is presented in the DONE state. An action passes through accept,
// execute with one store access, and deliver, and no new word is taken until
// the receiver has taken the result; the store's registered read sets the
// execute step.
// Reset (rst, synchronous) empties the queue and selects normal order; the
// store's contents are not cleared and are never read before being written.
// While the receiver stalls the result is held unchanged and no further
// input word is taken.
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse
// Top level: joins the sequencer and the queue datapath.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse
  import dqr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic        [2:0]                action,
  input  logic signed [31:0]               value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               popped_value,
  output logic        [1:0]                status,
  output logic        [$clog2(DEPTH+1)-1:0] entry_count
);

  dqr_cmd_t cmd;

  dqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dqr_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .value        (value),
    .popped_value (popped_value),
    .status       (status),
    .entry_count  (entry_count)
  );

endmodule

// ----- hw/rtl/dqr_checker.sv -----
// ----------------------------------------------------------------------------
// dqr_checker
// Port-level checks on the double-ended queue results, bound to the top.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_reverse_macros.svh"

module dqr_checker
  import dqr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [31:0]               popped_value,
  input logic        [1:0]                status,
  input logic        [$clog2(DEPTH+1)-1:0] entry_count
);

  localparam logic [$clog2(DEPTH+1)-1:0] DEPTH_C = ($clog2(DEPTH+1))'(DEPTH);

  `DQR_ASSERT(a_count_bound, out_valid |-> (entry_count <= DEPTH_C), "entry count above depth")

  `DQR_ASSERT(a_empty_refusal, (out_valid && status == STS_EMPTY) |-> (popped_value == 32'sd0 && entry_count == '0), "refused pop with data or entries")

  `DQR_ASSERT(a_full_refusal, (out_valid && status == STS_FULL) |-> (entry_count == DEPTH_C), "refused push while not full")

  `DQR_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(popped_value) && $stable(status) && $stable(entry_count)), "stalled result changed")

endmodule

bind double_ended_queue_with_reverse dqr_checker #(.DEPTH(DEPTH)) u_dqr_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue with order reversal. A
// backlog of actions (directed corner cases first, then random runs that
// drift the queue towards full or empty) is driven with random gaps, while
// the result side stalls at random. Each accepted word updates a local
// model of the queue, and each returned result is checked field by field
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import dqr_pkg::*;

  localparam int DEPTH = 16;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RANDOM_ACTIONS = 1600;
  localparam int IDLE_LIMIT = 1000;

  // codes the block must ignore
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] word;
    int                 gap;
    bit                 drain_first;
  } action_item_t;

  typedef struct {
    logic signed [31:0] popped;
    logic [1:0]         sts;
    logic [CW-1:0]      count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] action = ACT_PUSH_FRONT;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] popped_value;
  logic [1:0] status;
  logic [CW-1:0] entry_count;

  double_ended_queue_with_reverse #(.DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .popped_value(popped_value),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the queue
  logic signed [31:0] slots [DEPTH];
  int head_slot = 0;
  int live = 0;
  bit flipped = 1'b0;

  action_item_t action_backlog [$];
  reply_t due_replies [$];
  int backlog_total = 0;
  int words_sent = 0;
  int replies_seen = 0;
  int errors = 0;
  int pops_done = 0;
  int full_refusals = 0;
  int empty_refusals = 0;
  int reversals = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int calm_left = 0;
  bit word_taken = 1'b0;

  function automatic reply_t apply_action(logic [2:0] act, logic signed [31:0] word);
    reply_t r;
    bit at_first;
    r.popped = '0;
    r.sts = STS_DONE;
    at_first = (act == ACT_PUSH_FRONT || act == ACT_POP_FRONT) ^ flipped;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (live == DEPTH) begin
          r.sts = STS_FULL;
        end else begin
          if (live == 0) begin
            slots[head_slot] = word;
          end else if (at_first) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slots[head_slot] = word;
          end else begin
            slots[(head_slot + live) % DEPTH] = word;
          end
          live++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (live == 0) begin
          r.sts = STS_EMPTY;
        end else begin
          if (at_first) begin
            r.popped = slots[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
          end else begin
            r.popped = slots[(head_slot + live - 1) % DEPTH];
          end
          live--;
        end
      end
      ACT_REVERSE: flipped = ~flipped;
      default: ;
    endcase
    r.count = CW'(live);
    return r;
  endfunction

  task automatic add_action(logic [2:0] act, logic signed [31:0] word, int gap, bit drain);
    action_item_t it;
    it.act = act;
    it.word = word;
    it.gap = gap;
    it.drain_first = drain;
    action_backlog.push_back(it);
    backlog_total++;
  endtask

  function automatic logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'sh8000_0000;
    if (r < 6) return 32'sh7fff_ffff;
    if (r < 8) return '0;
    if (r < 10) return -32'sd1;
    return $urandom;
  endfunction

  function automatic int pick_gap(bit busy_run);
    int r;
    if (busy_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sender: present a word at the falling edge, hold it until taken
  always @(negedge clk) begin
    action_item_t nxt;
    if (!rst) begin
      if (in_valid && !word_taken) begin
        // hold
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (action_backlog.size() != 0 &&
                   !(action_backlog[0].drain_first && due_replies.size() != 0)) begin
        nxt = action_backlog.pop_front();
        in_valid <= 1'b1;
        action <= nxt.act;
        value <= nxt.word;
        gap_left <= nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: short and long stalls, with calm stretches in between
  always @(negedge clk) begin
    int r;
    if (!rst) begin
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (calm_left != 0) begin
          calm_left <= calm_left - 1;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 5) calm_left <= $urandom_range(50, 200);
          else if (r < 35) stall_left <= $urandom_range(1, 3);
          else if (r < 39) stall_left <= $urandom_range(10, 30);
        end
      end
    end
  end

  // monitor: predict on every accepted word, check every accepted result
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        want = apply_action(action, value);
        due_replies.push_back(want);
        words_sent++;
        if (want.sts == STS_FULL) full_refusals++;
        if (want.sts == STS_EMPTY) empty_refusals++;
        if ((action == ACT_POP_FRONT || action == ACT_POP_BACK) && want.sts == STS_DONE)
          pops_done++;
        if (action == ACT_REVERSE) reversals++;
      end
      if (out_valid && out_ready) begin
        replies_seen++;
        if (due_replies.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding: value %0d status %0d count %0d",
                   $time, popped_value, status, entry_count);
        end else begin
          want = due_replies.pop_front();
          got.popped = popped_value;
          got.sts = status;
          got.count = entry_count;
          if (got.popped !== want.popped) begin
            errors++;
            $display("%0t: popped_value expected %0d actual %0d",
                     $time, want.popped, got.popped);
          end
          if (got.sts !== want.sts) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.sts, got.sts);
          end
          if (got.count !== want.count) begin
            errors++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.count, got.count);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int made;
    int run_len;
    int push_pct;
    int r;
    bit busy_run;
    bit drain;
    logic [2:0] act;

    // corner cases: refused pops, reverse while empty, last entry out
    add_action(ACT_POP_FRONT, 32'sh7fff_ffff, 0, 1'b0);
    add_action(ACT_POP_BACK, 32'sh8000_0000, 1, 1'b0);
    add_action(ACT_REVERSE, -32'sd1, 0, 1'b0);
    add_action(ACT_PUSH_FRONT, 32'sh8000_0000, 0, 1'b0);
    add_action(ACT_PUSH_BACK, 32'sh7fff_ffff, 2, 1'b0);
    add_action(ACT_POP_BACK, '0, 0, 1'b0);
    add_action(ACT_REVERSE, '0, 0, 1'b0);
    add_action(ACT_POP_FRONT, '0, 0, 1'b0);
    add_action(ACT_SPARE_LAST, -32'sd1, 0, 1'b0);
    // fill to the brim, then one push too many
    for (int i = 0; i < DEPTH; i++)
      add_action((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                 (i % 3 == 0) ? -32'sd1 : 32'(i) << (2 * i), 0, 1'b0);
    add_action(ACT_PUSH_FRONT, 32'sh1234_5678, 0, 1'b0);

    // random runs, each leaning towards filling, draining or neither
    made = 0;
    drain = 1'b1;
    while (made < RANDOM_ACTIONS) begin
      run_len = $urandom_range(20, 80);
      r = $urandom_range(0, 2);
      push_pct = (r == 0) ? 85 : (r == 1) ? 50 : 15;
      busy_run = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < run_len && made < RANDOM_ACTIONS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2)
          act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        else if (r < 9)
          act = ACT_REVERSE;
        else if ($urandom_range(0, 99) < push_pct)
          act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else
          act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
        add_action(act, pick_word(), pick_gap(busy_run), drain);
        drain = 1'b0;
        made++;
      end
      drain = ($urandom_range(0, 4) == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_sent != backlog_total || due_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d actions, %0d results: %0d pops, %0d reversals,",
             words_sent, replies_seen, pops_done, reversals);
    $display("%0d pushes refused on a full queue, %0d pops refused on an empty one",
             full_refusals, empty_refusals);
    if (errors == 0 && due_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
